// ===== src/hrp_pkg.sv =====
// Shared types, state codes, character constants and byte classes for the
// HTTP request-head parser. No dependencies.
package hrp_pkg;

    localparam int VERSION_BITS_DEF = 8;

    typedef enum logic [19:0] {
        ST_METHOD_START = 20'h00001,
        ST_METHOD       = 20'h00002,
        ST_URI          = 20'h00004,
        ST_H            = 20'h00008,
        ST_T1           = 20'h00010,
        ST_T2           = 20'h00020,
        ST_P            = 20'h00040,
        ST_SLASH        = 20'h00080,
        ST_MAJ_START    = 20'h00100,
        ST_MAJ          = 20'h00200,
        ST_MIN_START    = 20'h00400,
        ST_MIN          = 20'h00800,
        ST_NL1          = 20'h01000,
        ST_LINE_START   = 20'h02000,
        ST_LWS          = 20'h04000,
        ST_NAME         = 20'h08000,
        ST_SP_VALUE     = 20'h10000,
        ST_VALUE        = 20'h20000,
        ST_NL2          = 20'h40000,
        ST_NL3          = 20'h80000
    } t_state;

    localparam logic [1:0] STAT_MORE = 2'd0;
    localparam logic [1:0] STAT_DONE = 2'd1;
    localparam logic [1:0] STAT_BAD  = 2'd2;

    localparam logic [2:0] KIND_NONE   = 3'd0;
    localparam logic [2:0] KIND_METHOD = 3'd1;
    localparam logic [2:0] KIND_URI    = 3'd2;
    localparam logic [2:0] KIND_NAME   = 3'd3;
    localparam logic [2:0] KIND_VALUE  = 3'd4;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_H     = 8'h48;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_DEL   = 8'h7F;
    localparam logic [7:0] CH_CTL_MAX = 8'h1F;

    typedef struct packed {
        logic [1:0] status;
        logic [2:0] kind;
        logic       new_header;
        logic [7:0] char_out;
    } t_result;

    function automatic logic is_control(input logic [7:0] b);
        return (b <= CH_CTL_MAX) || (b == CH_DEL);
    endfunction

    function automatic logic is_separator(input logic [7:0] b);
        logic sep;
        case (b) inside
            8'h28, 8'h29, 8'h3C, 8'h3E, 8'h40, 8'h2C, 8'h3B, 8'h3A, 8'h5C,
            8'h22, 8'h2F, 8'h5B, 8'h5D, 8'h3F, 8'h3D, 8'h7B, 8'h7D, 8'h20,
            8'h09: sep = 1'b1;
            default: sep = 1'b0;
        endcase
        return sep;
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= CH_ZERO) && (b <= CH_NINE);
    endfunction

    function automatic logic is_token(input logic [7:0] b);
        return !b[7] && !is_control(b) && !is_separator(b);
    endfunction

    function automatic logic is_lws(input logic [7:0] b);
        return (b == CH_SP) || (b == CH_TAB);
    endfunction

endpackage

// ===== src/hrp_step.sv =====
// Combinational per-byte transition of the request-head parser: next state,
// saturating version update and the result for one byte. Uses hrp_pkg.
module hrp_step #(
    parameter int VERSION_BITS = hrp_pkg::VERSION_BITS_DEF
) (
    input  hrp_pkg::t_state         i_state,
    input  logic                    i_header_seen,
    input  logic [VERSION_BITS-1:0] i_major,
    input  logic [VERSION_BITS-1:0] i_minor,
    input  logic                    i_action,
    input  logic [7:0]              i_byte,
    output hrp_pkg::t_state         o_state,
    output logic                    o_header_seen,
    output logic [VERSION_BITS-1:0] o_major,
    output logic [VERSION_BITS-1:0] o_minor,
    output hrp_pkg::t_result        o_result
);

    localparam int WIDE = VERSION_BITS + 4;
    localparam logic [WIDE-1:0] VMAX = WIDE'((1 << VERSION_BITS) - 1);

    function automatic logic [VERSION_BITS-1:0] add_digit(
        input logic [VERSION_BITS-1:0] v,
        input logic [7:0]              b
    );
        logic [WIDE-1:0] sum;
        sum = (WIDE'(v) << 3) + (WIDE'(v) << 1) + WIDE'(b[3:0]);
        return (sum > VMAX) ? VMAX[VERSION_BITS-1:0] : sum[VERSION_BITS-1:0];
    endfunction

    logic [VERSION_BITS-1:0] digit_major;
    logic [VERSION_BITS-1:0] digit_minor;

    assign digit_major = add_digit(i_major, i_byte);
    assign digit_minor = add_digit(i_minor, i_byte);

    always_comb begin
        o_state       = i_state;
        o_header_seen = i_header_seen;
        o_major       = i_major;
        o_minor       = i_minor;
        o_result.status     = hrp_pkg::STAT_MORE;
        o_result.kind       = hrp_pkg::KIND_NONE;
        o_result.new_header = 1'b0;
        o_result.char_out   = i_byte;
        if (i_action) begin
            o_state       = hrp_pkg::ST_METHOD_START;
            o_header_seen = 1'b0;
            o_major       = '0;
            o_minor       = '0;
            o_result.char_out = 8'd0;
        end else begin
            case (i_state)
                hrp_pkg::ST_METHOD_START: begin
                    if (hrp_pkg::is_token(i_byte)) begin
                        o_state = hrp_pkg::ST_METHOD;
                        o_result.kind = hrp_pkg::KIND_METHOD;
                    end else o_result.status = hrp_pkg::STAT_BAD;
                end
                hrp_pkg::ST_METHOD: begin
                    if (i_byte == hrp_pkg::CH_SP) o_state = hrp_pkg::ST_URI;
                    else if (hrp_pkg::is_token(i_byte)) o_result.kind = hrp_pkg::KIND_METHOD;
                    else o_result.status = hrp_pkg::STAT_BAD;
                end
                hrp_pkg::ST_URI: begin
                    if (i_byte == hrp_pkg::CH_SP) o_state = hrp_pkg::ST_H;
                    else if (hrp_pkg::is_control(i_byte)) o_result.status = hrp_pkg::STAT_BAD;
                    else o_result.kind = hrp_pkg::KIND_URI;
                end
                hrp_pkg::ST_H: begin
                    if (i_byte == hrp_pkg::CH_H) o_state = hrp_pkg::ST_T1;
                    else o_result.status = hrp_pkg::STAT_BAD;
                end
                hrp_pkg::ST_T1: begin
                    if (i_byte == hrp_pkg::CH_T) o_state = hrp_pkg::ST_T2;
                    else o_result.status = hrp_pkg::STAT_BAD;
                end
                hrp_pkg::ST_T2: begin
                    if (i_byte == hrp_pkg::CH_T) o_state = hrp_pkg::ST_P;
                    else o_result.status = hrp_pkg::STAT_BAD;
                end
                hrp_pkg::ST_P: begin
                    if (i_byte == hrp_pkg::CH_P) o_state = hrp_pkg::ST_SLASH;
                    else o_result.status = hrp_pkg::STAT_BAD;
                end
                hrp_pkg::ST_SLASH: begin
                    if (i_byte == hrp_pkg::CH_SLASH) begin
                        o_major = '0;
                        o_minor = '0;
                        o_state = hrp_pkg::ST_MAJ_START;
                    end else o_result.status = hrp_pkg::STAT_BAD;
                end
                hrp_pkg::ST_MAJ_START: begin
                    if (hrp_pkg::is_digit(i_byte)) begin
                        o_major = add_digit('0, i_byte);
                        o_state = hrp_pkg::ST_MAJ;
                    end else o_result.status = hrp_pkg::STAT_BAD;
                end
                hrp_pkg::ST_MAJ: begin
                    if (i_byte == hrp_pkg::CH_DOT) o_state = hrp_pkg::ST_MIN_START;
                    else if (hrp_pkg::is_digit(i_byte)) o_major = digit_major;
                    else o_result.status = hrp_pkg::STAT_BAD;
                end
                hrp_pkg::ST_MIN_START: begin
                    if (hrp_pkg::is_digit(i_byte)) begin
                        o_minor = add_digit('0, i_byte);
                        o_state = hrp_pkg::ST_MIN;
                    end else o_result.status = hrp_pkg::STAT_BAD;
                end
                hrp_pkg::ST_MIN: begin
                    if (i_byte == hrp_pkg::CH_CR) o_state = hrp_pkg::ST_NL1;
                    else if (hrp_pkg::is_digit(i_byte)) o_minor = digit_minor;
                    else o_result.status = hrp_pkg::STAT_BAD;
                end
                hrp_pkg::ST_NL1: begin
                    if (i_byte == hrp_pkg::CH_LF) o_state = hrp_pkg::ST_LINE_START;
                    else o_result.status = hrp_pkg::STAT_BAD;
                end
                hrp_pkg::ST_LINE_START: begin
                    if (i_byte == hrp_pkg::CH_CR) o_state = hrp_pkg::ST_NL3;
                    else if (i_header_seen && hrp_pkg::is_lws(i_byte)) begin
                        o_state = hrp_pkg::ST_LWS;
                    end else if (hrp_pkg::is_token(i_byte)) begin
                        o_header_seen       = 1'b1;
                        o_result.kind       = hrp_pkg::KIND_NAME;
                        o_result.new_header = 1'b1;
                        o_state             = hrp_pkg::ST_NAME;
                    end else o_result.status = hrp_pkg::STAT_BAD;
                end
                hrp_pkg::ST_LWS: begin
                    if (i_byte == hrp_pkg::CH_CR) o_state = hrp_pkg::ST_NL2;
                    else if (hrp_pkg::is_lws(i_byte)) o_state = hrp_pkg::ST_LWS;
                    else if (hrp_pkg::is_control(i_byte)) o_result.status = hrp_pkg::STAT_BAD;
                    else begin
                        o_result.kind = hrp_pkg::KIND_VALUE;
                        o_state       = hrp_pkg::ST_VALUE;
                    end
                end
                hrp_pkg::ST_NAME: begin
                    if (i_byte == hrp_pkg::CH_COLON) o_state = hrp_pkg::ST_SP_VALUE;
                    else if (hrp_pkg::is_token(i_byte)) o_result.kind = hrp_pkg::KIND_NAME;
                    else o_result.status = hrp_pkg::STAT_BAD;
                end
                hrp_pkg::ST_SP_VALUE: begin
                    if (i_byte == hrp_pkg::CH_SP) o_state = hrp_pkg::ST_VALUE;
                    else o_result.status = hrp_pkg::STAT_BAD;
                end
                hrp_pkg::ST_VALUE: begin
                    if (i_byte == hrp_pkg::CH_CR) o_state = hrp_pkg::ST_NL2;
                    else if (hrp_pkg::is_control(i_byte)) o_result.status = hrp_pkg::STAT_BAD;
                    else o_result.kind = hrp_pkg::KIND_VALUE;
                end
                hrp_pkg::ST_NL2: begin
                    if (i_byte == hrp_pkg::CH_LF) o_state = hrp_pkg::ST_LINE_START;
                    else o_result.status = hrp_pkg::STAT_BAD;
                end
                hrp_pkg::ST_NL3: begin
                    if (i_byte == hrp_pkg::CH_LF) o_result.status = hrp_pkg::STAT_DONE;
                    else o_result.status = hrp_pkg::STAT_BAD;
                end
                default: begin
                    o_result.status = hrp_pkg::STAT_BAD;
                end
            endcase
        end
    end

endmodule

// ===== src/http_request_header_parser_core.sv =====
// A result appears in the cycle after its request is accepted. Throughput:
// one request per cycle unless the output stalls; the state transition of
// hrp_step is registered once, and the result register frees as it is read.
// Reset is synchronous and active low: the parser returns to the method
// start, versions and header flag clear, and no result is pending.
module http_request_header_parser_core #(
    parameter int VERSION_BITS = hrp_pkg::VERSION_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] char_out, [15:8] version_major,
                                        // [23:16] version_minor
    output logic [5:0]  m_axis_tuser    // [1:0] status, [4:2] char_kind,
                                        // [5] new_header
);

    hrp_pkg::t_state         r_state;
    hrp_pkg::t_state         n_state;
    logic                    r_header_seen;
    logic                    n_header_seen;
    logic [VERSION_BITS-1:0] r_major;
    logic [VERSION_BITS-1:0] n_major;
    logic [VERSION_BITS-1:0] r_minor;
    logic [VERSION_BITS-1:0] n_minor;
    hrp_pkg::t_result        n_result;
    hrp_pkg::t_result        r_result;
    logic [7:0]              r_out_major;
    logic [7:0]              r_out_minor;
    logic                    r_out_valid;
    logic                    accept;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    hrp_step #(
        .VERSION_BITS(VERSION_BITS)
    ) u_step (
        .i_state       (r_state),
        .i_header_seen (r_header_seen),
        .i_major       (r_major),
        .i_minor       (r_minor),
        .i_action      (s_axis_tuser),
        .i_byte        (s_axis_tdata),
        .o_state       (n_state),
        .o_header_seen (n_header_seen),
        .o_major       (n_major),
        .o_minor       (n_minor),
        .o_result      (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= hrp_pkg::ST_METHOD_START;
            r_header_seen <= 1'b0;
            r_major       <= '0;
            r_minor       <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (accept) begin
                r_state       <= n_state;
                r_header_seen <= n_header_seen;
                r_major       <= n_major;
                r_minor       <= n_minor;
                r_out_valid   <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_result    <= n_result;
            r_out_major <= 8'(n_major);
            r_out_minor <= 8'(n_minor);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_minor, r_out_major, r_result.char_out};
    assign m_axis_tuser  = {r_result.new_header, r_result.kind, r_result.status};

    // A rejected byte must leave the parse state untouched.
    a_bad_holds_state: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (accept && !s_axis_tuser && n_result.status == hrp_pkg::STAT_BAD)
            |=> (r_state == $past(r_state) && r_major == $past(r_major)
                 && r_minor == $past(r_minor))
    ) else $error("bad byte changed parser state");

    // A bad result carries no character tag.
    a_bad_untagged: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && r_result.status == hrp_pkg::STAT_BAD)
            |-> (r_result.kind == hrp_pkg::KIND_NONE && !r_result.new_header)
    ) else $error("bad result carries a tag");

    // A new header is always flagged on a header-name character.
    a_new_header_is_name: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && r_result.new_header)
            |-> (r_result.kind == hrp_pkg::KIND_NAME && r_header_seen)
    ) else $error("new header without a name character");

    // Completion only occurs from the final line-feed state.
    a_done_state: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && r_result.status == hrp_pkg::STAT_DONE)
            |-> (r_state == hrp_pkg::ST_NL3)
    ) else $error("completion outside the final state");

endmodule
